// ----- hdl/pfr_pkg.sv -----
`default_nettype none
package pfr_pkg;

	localparam int TAPS       = 32;
	localparam int PHASES     = 64;
	localparam int MAX_OUT    = 6;
	localparam int TAP_W      = 5;
	localparam int ROW_W      = 7;
	localparam int PHASE_W    = 6;
	localparam int WEIGHT_W   = 8;
	localparam int QUO_W      = PHASE_W + WEIGHT_W;
	localparam int COEF_DEPTH = (PHASES + 1) * TAPS;
	localparam int ADDR_W     = ROW_W + TAP_W;
	localparam int RATE_W     = 16;
	localparam int ACC_W      = 17;
	localparam int SUM_W      = 37;
	localparam int BLEND_W    = SUM_W + WEIGHT_W + 2;
	localparam int CNT_W      = 5;
	localparam int N_W        = 3;
	localparam int SHIFT      = 23;
	localparam int ROUND_BIAS = 1 << 22;
	localparam int BLEND_ONE  = 256;
	localparam int SAT_HI     = 32767;
	localparam int SAT_LO     = -32768;
	localparam int RATE_RESET = 48000;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	localparam logic REG_IN_RATE  = 1'b0;
	localparam logic REG_OUT_RATE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_MAC,
		ST_DRAIN,
		ST_BLEND,
		ST_ROUND,
		ST_EMIT,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic             audio_wr;
		logic             coef_wr;
		logic             div_start;
		logic             div_step;
		logic             mac_issue;
		logic [TAP_W-1:0] tap;
		logic             blend;
		logic             round;
		logic             emit;
		logic             last;
		logic             finish;
	} cmd_t;

	typedef struct packed {
		logic acc_lt_rate;
		logic mac_busy;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- hdl/pfr_ctrl.sv -----
`default_nettype none
module pfr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          opcode,
	input  wire pfr_pkg::sts_t sts,
	output pfr_pkg::cmd_t      cmd
);

	localparam int N_W   = pfr_pkg::N_W;
	localparam int CNT_W = pfr_pkg::CNT_W;

	pfr_pkg::state_t                state_q, state_d;
	logic [pfr_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic [pfr_pkg::N_W-1:0]        n_q, n_d;
	logic                           accept;
	logic                           more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfr_pkg::ST_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			n_q     <= n_d;
		end
	end

	assign in_stall = (state_q != pfr_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign more     = sts.acc_lt_rate &&
		(N_W'(n_q + N_W'(1)) < N_W'(pfr_pkg::MAX_OUT));

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		n_d     = n_q;
		cmd     = '0;
		cmd.tap = cnt_q;
		unique case (state_q)
			pfr_pkg::ST_IDLE: begin
				if (accept) begin
					if (opcode == pfr_pkg::OP_COEF) begin
						cmd.coef_wr = 1'b1;
					end else begin
						cmd.audio_wr = 1'b1;
						n_d          = '0;
						state_d      = pfr_pkg::ST_CHECK;
					end
				end
			end
			pfr_pkg::ST_CHECK: begin
				if (sts.acc_lt_rate && (n_q < N_W'(pfr_pkg::MAX_OUT))) begin
					cmd.div_start = 1'b1;
					cnt_d         = '0;
					state_d       = pfr_pkg::ST_DIV;
				end else begin
					state_d = pfr_pkg::ST_FINAL;
				end
			end
			pfr_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(pfr_pkg::QUO_W - 1)) begin
					cnt_d   = '0;
					state_d = pfr_pkg::ST_MAC;
				end else begin
					cnt_d = CNT_W'(cnt_q + CNT_W'(1));
				end
			end
			pfr_pkg::ST_MAC: begin
				cmd.mac_issue = 1'b1;
				if (cnt_q == CNT_W'(pfr_pkg::TAPS - 1)) begin
					cnt_d   = '0;
					state_d = pfr_pkg::ST_DRAIN;
				end else begin
					cnt_d = CNT_W'(cnt_q + CNT_W'(1));
				end
			end
			pfr_pkg::ST_DRAIN: begin
				if (!sts.mac_busy) begin
					state_d = pfr_pkg::ST_BLEND;
				end
			end
			pfr_pkg::ST_BLEND: begin
				cmd.blend = 1'b1;
				state_d   = pfr_pkg::ST_ROUND;
			end
			pfr_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = pfr_pkg::ST_EMIT;
			end
			pfr_pkg::ST_EMIT: begin
				cmd.last = !more;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					n_d      = N_W'(n_q + N_W'(1));
					state_d  = more ? pfr_pkg::ST_CHECK : pfr_pkg::ST_FINAL;
				end
			end
			pfr_pkg::ST_FINAL: begin
				cmd.finish = 1'b1;
				state_d    = pfr_pkg::ST_IDLE;
			end
			default: begin
				state_d = pfr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/pfr_datapath.sv -----
`default_nettype none
module pfr_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic                                cfg_index,
	input  wire logic        [pfr_pkg::RATE_W-1:0]   cfg_data,
	input  wire logic signed [15:0]                  sample_in,
	input  wire logic        [pfr_pkg::ROW_W-1:0]    coef_row,
	input  wire logic        [pfr_pkg::TAP_W-1:0]    coef_tap,
	input  wire logic signed [15:0]                  coef_value,
	input  wire logic                                out_stall,
	output logic                                     out_valid,
	output logic signed      [15:0]                  sample_out,
	output logic                                     last,
	input  wire pfr_pkg::cmd_t                       cmd,
	output pfr_pkg::sts_t                            sts
);

	localparam int ACC_W   = pfr_pkg::ACC_W;
	localparam int RATE_W  = pfr_pkg::RATE_W;
	localparam int SUM_W   = pfr_pkg::SUM_W;
	localparam int BLEND_W = pfr_pkg::BLEND_W;
	localparam int TOT_W   = BLEND_W + 1;
	localparam int SH_W    = TOT_W - pfr_pkg::SHIFT;
	localparam int W_W     = pfr_pkg::WEIGHT_W;
	localparam int TAP_W   = pfr_pkg::TAP_W;
	localparam int ROW_W   = pfr_pkg::ROW_W;
	localparam int QUO_W   = pfr_pkg::QUO_W;

	logic        [RATE_W-1:0] in_rate_q, out_rate_q;
	logic        [ACC_W-1:0]  phase_q;
	logic        [TAP_W-1:0]  head_q;
	logic signed [15:0]       hist_q [pfr_pkg::TAPS];
	logic signed [15:0]       coef_mem [pfr_pkg::COEF_DEPTH];

	logic        [RATE_W-1:0] rem_q;
	logic        [QUO_W-1:0]  quo_q;
	logic        [RATE_W:0]   rem_dbl;

	logic        [pfr_pkg::PHASE_W-1:0] row;
	logic        [W_W-1:0]              weight;
	logic        [ROW_W-1:0]            row_b;
	logic        [pfr_pkg::ADDR_W-1:0]  addr_a, addr_b, addr_w;
	logic        [TAP_W-1:0]            hist_idx;

	logic                     v_s1, v_s2;
	logic signed [15:0]       ca_s1, cb_s1, h_s1;
	logic signed [31:0]       pa_s2, pb_s2;
	logic signed [SUM_W-1:0]  sum_a_q, sum_b_q;

	logic signed [W_W+1:0]    wa, wb;
	logic signed [BLEND_W-1:0] ba_s1, bb_s1;
	logic signed [TOT_W-1:0]  total;
	logic signed [SH_W-1:0]   shifted;
	logic signed [15:0]       sat;
	logic signed [15:0]       result_q;

	logic                     out_valid_q;
	logic signed [15:0]       sample_out_q;
	logic                     last_q;

	// configuration and phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rate_q  <= RATE_W'(pfr_pkg::RATE_RESET);
			out_rate_q <= RATE_W'(pfr_pkg::RATE_RESET);
			phase_q    <= '0;
			head_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					pfr_pkg::REG_IN_RATE:  in_rate_q  <= cfg_data;
					pfr_pkg::REG_OUT_RATE: out_rate_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.div_start) begin
				phase_q <= ACC_W'(phase_q + {1'b0, in_rate_q});
			end else if (cmd.finish) begin
				if (phase_q >= {1'b0, out_rate_q}) begin
					phase_q <= ACC_W'(phase_q - {1'b0, out_rate_q});
				end else begin
					phase_q <= '0;
				end
				head_q <= TAP_W'(head_q + TAP_W'(1));
			end
		end
	end

	assign sts.acc_lt_rate = (phase_q < {1'b0, out_rate_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pfr_pkg::TAPS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (cmd.audio_wr) begin
			hist_q[head_q] <= sample_in;
		end
	end

	// phase * 64 * 256 / out_rate_q, one quotient bit a cycle
	assign rem_dbl = {rem_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= phase_q[RATE_W-1:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_dbl >= {1'b0, out_rate_q}) begin
				rem_q <= RATE_W'(rem_dbl - {1'b0, out_rate_q});
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_dbl[RATE_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign row      = quo_q[QUO_W-1:W_W];
	assign weight   = quo_q[W_W-1:0];
	assign row_b    = ROW_W'({1'b0, row} + ROW_W'(1));
	assign addr_a   = {1'b0, row, cmd.tap};
	assign addr_b   = {row_b, cmd.tap};
	assign addr_w   = {coef_row, coef_tap};
	assign hist_idx = TAP_W'(head_q - cmd.tap);

	always_ff @(posedge clk) begin
		if (cmd.coef_wr && (coef_row <= ROW_W'(pfr_pkg::PHASES))) begin
			coef_mem[addr_w] <= coef_value;
		end
		ca_s1 <= coef_mem[addr_a];
		cb_s1 <= coef_mem[addr_b];
	end

	// tap pipeline: read, multiply, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.mac_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		h_s1  <= hist_q[hist_idx];
		pa_s2 <= h_s1 * ca_s1;
		pb_s2 <= h_s1 * cb_s1;
		if (cmd.div_start) begin
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (v_s2) begin
			sum_a_q <= sum_a_q + SUM_W'(pa_s2);
			sum_b_q <= sum_b_q + SUM_W'(pb_s2);
		end
	end

	assign sts.mac_busy = v_s1 || v_s2;

	// blend, round, saturate
	assign wb = $signed({2'b00, weight});
	assign wa = $signed((W_W+2)'(pfr_pkg::BLEND_ONE) - (W_W+2)'(weight));

	always_ff @(posedge clk) begin
		if (cmd.blend) begin
			ba_s1 <= sum_a_q * wa;
			bb_s1 <= sum_b_q * wb;
		end
	end

	assign total   = TOT_W'(ba_s1) + TOT_W'(bb_s1) + TOT_W'(pfr_pkg::ROUND_BIAS);
	assign shifted = total[TOT_W-1:pfr_pkg::SHIFT];

	always_comb begin
		if (shifted > SH_W'(pfr_pkg::SAT_HI)) begin
			sat = 16'(pfr_pkg::SAT_HI);
		end else if (shifted < SH_W'(pfr_pkg::SAT_LO)) begin
			sat = 16'(pfr_pkg::SAT_LO);
		end else begin
			sat = shifted[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round) begin
			result_q <= sat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sample_out_q <= result_q;
			last_q       <= cmd.last;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign sample_out   = sample_out_q;
	assign last         = last_q;

endmodule
`default_nettype wire

// ----- hdl/polyphase_fir_resampler_top.sv -----
// Coefficient write: taken from idle, no result; the controller stays idle.
// Audio item: each result goes through check, a 14-bit divider, 32 taps on the MAC, the drain,
// blend, round and load into the output register, which waits while out_stall holds it; the
// next item is taken once the controller has passed its final state and is idle again.
// Throughput is set by the single shared dual MAC walking the 32 taps.
// Reset clears the history, write head, phase and control; rates return to 48000.
`default_nettype none
module polyphase_fir_resampler_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic                              cfg_index,
	input  wire logic        [pfr_pkg::RATE_W-1:0] cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic signed [15:0]                sample_in,
	input  wire logic        [pfr_pkg::ROW_W-1:0]  coef_row,
	input  wire logic        [pfr_pkg::TAP_W-1:0]  coef_tap,
	input  wire logic signed [15:0]                coef_value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed      [15:0]                sample_out,
	output logic                                   last
);

	pfr_pkg::cmd_t cmd;
	pfr_pkg::sts_t sts;

	pfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_in),
		.coef_row   (coef_row),
		.coef_tap   (coef_tap),
		.coef_value (coef_value),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.sample_out (sample_out),
		.last       (last),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule
`default_nettype wire
